// ----- rtl/slms_pkg.sv -----
// ---------------------------------------------------------------------------
// slms_pkg
// Shared types and constants for the scrolling LED matrix scanner.
// ---------------------------------------------------------------------------
package slms_pkg;

    localparam int MATRIX_SIZE = 8;
    localparam int ROW_IDX_W   = 3;
    localparam int PIX_W       = 8;
    localparam int SLOT_FLD_W  = 6;
    localparam int PERIOD_W    = 16;
    localparam int COUNT_W     = 6;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd300;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 6'd11;
    localparam logic [PERIOD_W-1:0] TICKS_MAX  = 16'hFFFF;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic [PIX_W-1:0] column_drive;
        logic [PIX_W-1:0] row_drive;
        logic             scrolled;
    } t_result;

endpackage

// ----- rtl/scrolling_led_matrix_scanner.sv -----
// ---------------------------------------------------------------------------
// scrolling_led_matrix_scanner
// Scans a multiplexed 8x8 LED matrix and scrolls glyphs held in a glyph
// store memory, one column per tick transaction.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_stall      i_action, i_glyph_slot,
//                                               i_glyph_row, i_glyph_bits
//   output    out        o_valid / i_stall      o_column_drive, o_row_drive,
//                                               o_scrolled
//   config    in         APB psel/penable/...   scroll_period @0, char_count @4
//
// A tick uses the single glyph store read port twice (current slot, then
// the following slot), so no new tick is accepted during the second read;
// the row is formed from both reads and held in the output register.
// After reset a clearing pass zeroes every store address, during which
// o_stall is high. The output register plus a pending slot keep ticks
// flowing while the downstream stalls.
// ---------------------------------------------------------------------------
module scrolling_led_matrix_scanner
    import slms_pkg::*;
#(
    parameter int GLYPH_SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [SLOT_FLD_W-1:0]         i_glyph_slot,
    input  logic [ROW_IDX_W-1:0]          i_glyph_row,
    input  logic [PIX_W-1:0]              i_glyph_bits,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [PIX_W-1:0]              o_column_drive,
    output logic [PIX_W-1:0]              o_row_drive,
    output logic                          o_scrolled,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready
);

    localparam int SLOT_W = $clog2(GLYPH_SLOTS);
    localparam int DEPTH  = GLYPH_SLOTS * MATRIX_SIZE;
    localparam int ADDR_W = SLOT_W + ROW_IDX_W;
    localparam logic [8:0]        SLOTS_LIM = 9'(GLYPH_SLOTS);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    // configuration
    logic [PERIOD_W-1:0] r_scroll_period;
    logic [COUNT_W-1:0]  r_char_count;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_period <= PERIOD_RST;
            r_char_count    <= COUNT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PERIOD) begin
                r_scroll_period <= pwdata[PERIOD_W-1:0];
            end else begin
                r_char_count <= pwdata[COUNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_COUNT) begin
            prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, r_char_count};
        end else begin
            prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, r_scroll_period};
        end
    end

    // control state
    logic                  r_clr_busy;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [PERIOD_W-1:0]   r_elapsed;
    logic [ROW_IDX_W-1:0]  r_scan_col;
    logic [ROW_IDX_W-1:0]  r_next_off;
    logic [SLOT_FLD_W-1:0] r_next_slot;
    logic [ROW_IDX_W-1:0]  r_shown_off;
    logic [SLOT_FLD_W-1:0] r_shown_slot;
    logic                  r_ph_b;
    logic                  r_ph_c;
    logic                  r_out_valid;
    logic                  r_pend_valid;

    // pipeline payload
    logic [SLOT_FLD_W:0]   r_slot_b;
    logic [ROW_IDX_W-1:0]  r_col;
    logic [ROW_IDX_W-1:0]  r_off;
    logic                  r_scr;
    logic                  r_a_ok;
    logic                  r_b_ok;
    logic [PIX_W-1:0]      r_a;
    logic [PIX_W-1:0]      r_rd_data;
    t_result               r_out;
    t_result               r_pend;

    logic [PIX_W-1:0]      r_mem [DEPTH];

    // handshake
    logic [1:0] occupancy;
    logic       tick_block;
    logic       acc;
    logic       tick_acc;
    logic       wr_acc;
    logic       take;
    logic       out_free;

    assign occupancy  = 2'(r_out_valid) + 2'(r_pend_valid) + 2'(r_ph_b) + 2'(r_ph_c);
    assign tick_block = r_ph_b | (occupancy >= 2'd2);
    assign o_stall    = r_clr_busy | ((i_action == ACT_TICK) & tick_block);
    assign acc        = i_valid & ~o_stall;
    assign tick_acc   = acc & (i_action == ACT_TICK);
    assign wr_acc     = acc & (i_action == ACT_WRITE);
    assign take       = r_out_valid & ~i_stall;
    assign out_free   = ~r_out_valid | take;

    // tick position update
    logic [PERIOD_W-1:0]   n_elapsed;
    logic                  hit;
    logic [ROW_IDX_W-1:0]  cur_off;
    logic [SLOT_FLD_W-1:0] cur_slot;
    logic [SLOT_FLD_W:0]   slot_inc;
    logic [SLOT_FLD_W-1:0] n_next_slot;

    always_comb begin
        n_elapsed = (r_elapsed != TICKS_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        hit       = (n_elapsed >= r_scroll_period);
        cur_off   = hit ? r_next_off  : r_shown_off;
        cur_slot  = hit ? r_next_slot : r_shown_slot;
        slot_inc  = {1'b0, r_next_slot} + 1'b1;
        if (r_next_off != 3'd7) begin
            n_next_slot = r_next_slot;
        end else if (slot_inc >= ({1'b0, r_char_count} + 1'b1)) begin
            n_next_slot = '0;
        end else begin
            n_next_slot = slot_inc[SLOT_FLD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_scan_col   <= '0;
            r_next_off   <= '0;
            r_next_slot  <= '0;
            r_shown_off  <= '0;
            r_shown_slot <= '0;
        end else if (tick_acc) begin
            r_scan_col <= r_scan_col + 1'b1;
            if (hit) begin
                r_elapsed    <= '0;
                r_shown_off  <= r_next_off;
                r_shown_slot <= r_next_slot;
                r_next_off   <= r_next_off + 1'b1;
                r_next_slot  <= n_next_slot;
            end else begin
                r_elapsed <= n_elapsed;
            end
        end
    end

    // glyph store access
    logic [8:0]        rd_slot;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;
    logic [8:0]        wr_slot;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [PIX_W-1:0]  mem_wdata;

    always_comb begin
        rd_slot = r_ph_b ? 9'(r_slot_b) : 9'(cur_slot);
        rd_ok   = (rd_slot < SLOTS_LIM);
        rd_addr = {rd_slot[SLOT_W-1:0], (r_ph_b ? r_col : r_scan_col)};
        wr_slot = 9'(i_glyph_slot);
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = wr_acc & (wr_slot < SLOTS_LIM);
            mem_waddr = {wr_slot[SLOT_W-1:0], i_glyph_row};
            mem_wdata = i_glyph_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // read sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_b <= 1'b0;
            r_ph_c <= 1'b0;
        end else begin
            r_ph_b <= tick_acc;
            r_ph_c <= r_ph_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_slot_b <= {1'b0, cur_slot} + 1'b1;
            r_col    <= r_scan_col;
            r_off    <= cur_off;
            r_scr    <= hit;
            r_a_ok   <= rd_ok;
        end
        if (r_ph_b) begin
            r_a    <= r_a_ok ? r_rd_data : '0;
            r_b_ok <= rd_ok;
        end
    end

    // row formation
    t_result          land;
    logic [PIX_W-1:0] b_bits;
    logic [PIX_W-1:0] b_part;

    always_comb begin
        b_bits = r_b_ok ? r_rd_data : '0;
        b_part = (r_off == '0) ? '0 : (b_bits >> (4'd8 - {1'b0, r_off}));
        land.column_drive = ~(8'b1 << r_col);
        land.row_drive    = (r_a << r_off) | b_part;
        land.scrolled     = r_scr;
    end

    // output register and pending slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= r_ph_c;
            end else begin
                r_out_valid <= r_ph_c;
            end
        end else if (r_ph_c) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
                if (r_ph_c) begin
                    r_pend <= land;
                end
            end else if (r_ph_c) begin
                r_out <= land;
            end
        end else if (r_ph_c) begin
            r_pend <= land;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_column_drive = r_out.column_drive;
    assign o_row_drive    = r_out.row_drive;
    assign o_scrolled     = r_out.scrolled;

endmodule

// ----- sim/scrolling_led_matrix_scanner_tb.sv -----
// ---------------------------------------------------------------------------
// scrolling_led_matrix_scanner_tb
// Self-checking testbench for the scrolling LED matrix scanner. A scoreboard
// mirrors the glyph store, the tick counter and the scroll position, and it
// works out the column, row and scroll flags of every accepted tick. The
// checker compares each result transaction with the oldest pending frame.
// Directed tests cover the register defaults, glyph extremes, a zero period,
// a lowered period, a full output path, the last store slot and the longest
// period. A randomized part then runs under changing register settings with
// random pacing on both channels.
// ---------------------------------------------------------------------------
module scrolling_led_matrix_scanner_tb;
    import slms_pkg::*;

    localparam int GLYPH_SLOTS      = 64;
    localparam int IDLE_LIMIT       = 4000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int HOLD_OFF_CYCLES  = 200;
    localparam int RANDOM_PHASES    = 4;
    localparam int PHASE_ITEMS      = 75;
    localparam int MAX_PERIOD_TICKS = 40;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_stall;
    logic                  i_action     = ACT_TICK;
    logic [SLOT_FLD_W-1:0] i_glyph_slot = '0;
    logic [ROW_IDX_W-1:0]  i_glyph_row  = '0;
    logic [PIX_W-1:0]      i_glyph_bits = '0;
    logic                  o_valid;
    logic                  i_stall      = 1'b0;
    logic [PIX_W-1:0]      o_column_drive;
    logic [PIX_W-1:0]      o_row_drive;
    logic                  o_scrolled;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [PIX_W-1:0]      glyph_mem [GLYPH_SLOTS*MATRIX_SIZE];
    logic [PERIOD_W-1:0]   cfg_period = PERIOD_RST;
    logic [COUNT_W-1:0]    cfg_count  = COUNT_RST;
    logic [PERIOD_W-1:0]   tick_count = '0;
    logic [2:0]            scan_col   = '0;
    logic [2:0]            pend_ofs   = '0;
    logic [SLOT_FLD_W-1:0] pend_slot  = '0;
    logic [2:0]            disp_ofs   = '0;
    logic [SLOT_FLD_W-1:0] disp_slot  = '0;

    t_result frames_due[$];
    t_result got_frame;
    t_result exp_frame;
    int      err_count   = 0;
    int      idle_cycles = 0;
    int      stall_left  = 0;
    int      hold_off    = 0;
    bit      pace_on     = 1'b1;

    scrolling_led_matrix_scanner #(
        .GLYPH_SLOTS(GLYPH_SLOTS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_glyph_slot   (i_glyph_slot),
        .i_glyph_row    (i_glyph_row),
        .i_glyph_bits   (i_glyph_bits),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_column_drive (o_column_drive),
        .o_row_drive    (o_row_drive),
        .o_scrolled     (o_scrolled),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] expd,
                                   input logic [31:0] actual);
        err_count++;
        if (err_count <= 10) begin
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, expd, actual);
        end
    endtask

    function automatic logic [PIX_W-1:0] glyph_at(input int slot, input int row);
        if (slot >= GLYPH_SLOTS) begin
            return '0;
        end
        return glyph_mem[slot*MATRIX_SIZE + row];
    endfunction

    task automatic scan_predict(input logic act, input logic [SLOT_FLD_W-1:0] slot,
                                input logic [ROW_IDX_W-1:0] row,
                                input logic [PIX_W-1:0] bits);
        t_result          f;
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] nxt;
        int               k;
        int               ns;
        if (act == ACT_WRITE) begin
            glyph_mem[int'(slot)*MATRIX_SIZE + int'(row)] = bits;
        end else begin
            f.scrolled = 1'b0;
            if (tick_count != TICKS_MAX) begin
                tick_count = tick_count + 1'b1;
            end
            if (tick_count >= cfg_period) begin
                tick_count = '0;
                disp_ofs   = pend_ofs;
                disp_slot  = pend_slot;
                f.scrolled = 1'b1;
                pend_ofs   = pend_ofs + 1'b1;
                if (pend_ofs == 3'd0) begin
                    ns = int'(pend_slot) + 1;
                    pend_slot = (ns >= int'(cfg_count) + 1) ? '0 : SLOT_FLD_W'(ns);
                end
            end
            k   = int'(disp_ofs);
            cur = glyph_at(int'(disp_slot), int'(scan_col));
            nxt = glyph_at(int'(disp_slot) + 1, int'(scan_col));
            f.column_drive = ~(8'b1 << scan_col);
            f.row_drive    = (cur << k) | ((k == 0) ? 8'h00 : (nxt >> (8 - k)));
            scan_col = scan_col + 1'b1;
            frames_due.push_back(f);
        end
    endtask

    task automatic send_item(input logic act, input logic [SLOT_FLD_W-1:0] slot,
                             input logic [ROW_IDX_W-1:0] row,
                             input logic [PIX_W-1:0] bits);
        int gap;
        gap = pace_on ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_glyph_slot <= slot;
        i_glyph_row  <= row;
        i_glyph_bits <= bits;
        do @(posedge i_clk); while (o_stall);
        scan_predict(act, slot, row, bits);
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, SLOT_FLD_W'($urandom), ROW_IDX_W'($urandom), PIX_W'($urandom));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (frames_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_read(input logic idx, input logic [APB_DATA_W-1:0] expd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== expd) begin
            report_mismatch(idx == REG_PERIOD ? "scroll_period readback" :
                            "char_count readback", expd, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_PERIOD) begin
            cfg_period = data[PERIOD_W-1:0];
        end else begin
            cfg_count = data[COUNT_W-1:0];
        end
        reg_read(idx, idx == REG_PERIOD ? APB_DATA_W'(cfg_period) : APB_DATA_W'(cfg_count));
    endtask

    task automatic set_config(input logic [PERIOD_W-1:0] period,
                              input logic [COUNT_W-1:0] count);
        settle();
        reg_write(REG_PERIOD, APB_DATA_W'(period));
        reg_write(REG_COUNT, APB_DATA_W'(count));
    endtask

    task automatic test_reset_defaults();
        reg_read(REG_PERIOD, APB_DATA_W'(PERIOD_RST));
        reg_read(REG_COUNT, APB_DATA_W'(COUNT_RST));
        repeat (8) send_tick();
    endtask

    task automatic test_glyph_extremes();
        set_config(16'd1, 6'd2);
        send_item(ACT_WRITE, 6'd1, 3'd0, 8'hFF);
        send_item(ACT_WRITE, 6'd1, 3'd7, 8'h80);
        send_item(ACT_WRITE, 6'd2, 3'd0, 8'h01);
        send_item(ACT_WRITE, 6'd2, 3'd7, 8'hA5);
        send_item(ACT_WRITE, 6'd3, 3'd0, 8'hFF);
        send_item(ACT_WRITE, 6'd0, 3'd3, 8'h5A);
        send_item(ACT_WRITE, 6'd63, 3'd7, 8'hFF);
        send_item(ACT_WRITE, 6'd1, 3'd4, 8'h00);
        send_item(ACT_TICK, 6'd63, 3'd7, 8'hFF);
        send_item(ACT_TICK, 6'd0, 3'd0, 8'h00);
        repeat (14) send_tick();
    endtask

    task automatic test_period_zero();
        set_config(16'd0, 6'd3);
        repeat (12) send_tick();
    endtask

    task automatic test_period_lowered();
        set_config(16'd1000, 6'd4);
        repeat (30) send_tick();
        set_config(16'd3, 6'd4);
        repeat (6) send_tick();
    endtask

    task automatic test_output_backpressure();
        set_config(16'd2, 6'd5);
        hold_off = HOLD_OFF_CYCLES;
        repeat (40) begin
            if ($urandom_range(0, 4) == 0) begin
                send_item(ACT_WRITE, SLOT_FLD_W'($urandom_range(0, 6)),
                          ROW_IDX_W'($urandom), PIX_W'($urandom));
            end else begin
                send_tick();
            end
        end
    endtask

    task automatic test_last_slot();
        set_config(16'd1, 6'd63);
        for (int r = 0; r < MATRIX_SIZE; r++) begin
            send_item(ACT_WRITE, 6'd63, ROW_IDX_W'(r), PIX_W'($urandom));
            send_item(ACT_WRITE, 6'd62, ROW_IDX_W'(r), PIX_W'($urandom));
        end
        repeat (GLYPH_SLOTS*MATRIX_SIZE + 16) send_tick();
    endtask

    task automatic test_period_max();
        set_config(16'hFFFF, 6'd7);
        pace_on = 1'b0;
        repeat (MAX_PERIOD_TICKS) send_tick();
        pace_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int                    sel;
        logic [PERIOD_W-1:0]   period;
        logic [COUNT_W-1:0]    count;
        logic [SLOT_FLD_W-1:0] slot;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sel = $urandom_range(0, 9);
            period = (sel < 6) ? PERIOD_W'($urandom_range(1, 4)) :
                     (sel < 9) ? PERIOD_W'($urandom_range(5, 40)) : '0;
            count  = COUNT_W'($urandom_range(1, 62));
            if (p == 0) begin
                period = 16'd1;
                count  = 6'd1;
            end else if (p == 1) begin
                period = 16'd2;
                count  = 6'd62;
            end
            set_config(period, count);
            pace_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 3) begin
                    slot = $urandom_range(0, 1) ?
                           SLOT_FLD_W'($urandom_range(0, (int'(count) + 1 > 63) ? 63 :
                                                          int'(count) + 1)) :
                           SLOT_FLD_W'($urandom_range(0, 63));
                    send_item(ACT_WRITE, slot, ROW_IDX_W'($urandom), PIX_W'($urandom));
                end else begin
                    send_tick();
                end
            end
        end
        pace_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_frame.column_drive = o_column_drive;
            got_frame.row_drive    = o_row_drive;
            got_frame.scrolled     = o_scrolled;
            if (frames_due.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected result transaction: column 0x%0h rows 0x%0h",
                             o_column_drive, o_row_drive);
                end
            end else begin
                exp_frame = frames_due.pop_front();
                if (got_frame.column_drive !== exp_frame.column_drive) begin
                    report_mismatch("column_drive", exp_frame.column_drive,
                                    got_frame.column_drive);
                end
                if (got_frame.row_drive !== exp_frame.row_drive) begin
                    report_mismatch("row_drive", exp_frame.row_drive, got_frame.row_drive);
                end
                if (got_frame.scrolled !== exp_frame.scrolled) begin
                    report_mismatch("scrolled", exp_frame.scrolled, got_frame.scrolled);
                end
            end
            stall_left = pace_on ? $urandom_range(0, 3) : 0;
        end
        if (hold_off > 0) begin
            hold_off--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("scrolling_led_matrix_scanner_tb failed");
            $finish;
        end
    end

    initial begin
        foreach (glyph_mem[i]) begin
            glyph_mem[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_glyph_extremes();
        test_period_zero();
        test_period_lowered();
        test_output_backpressure();
        test_last_slot();
        test_period_max();
        test_random_traffic();
        settle();
        if (err_count == 0 && frames_due.size() == 0) begin
            $display("scrolling_led_matrix_scanner_tb passed");
        end else begin
            $display("scrolling_led_matrix_scanner_tb failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/slms_pkg.sv
rtl/scrolling_led_matrix_scanner.sv
sim/scrolling_led_matrix_scanner_tb.sv
